// File: src/syrk_pkg.sv
// ----------------------------------------------------------------------------
// syrk_pkg
// Shared constants, tables and helpers for the ship yaw RK4 step block.
// ----------------------------------------------------------------------------
`default_nettype none

package syrk_pkg;

  // register map, indexed by word address
  localparam logic REG_STEP_SIZE   = 1'b0;
  localparam logic REG_RUDDER_RATE = 1'b1;

  localparam logic [24:0] STEP_SIZE_RST   = 25'd167772;
  localparam logic [24:0] RUDDER_RATE_RST = 25'd6710886;

  // model coefficients, Q.COEF_FRAC
  localparam int COEF_FRAC = 20;
  localparam logic signed [32:0] YA_O = 33'sd1069693409;
  localparam logic signed [32:0] YA_D = 33'sd31685231;
  localparam logic signed [32:0] YA_Y = 33'sd13512953;
  localparam logic signed [32:0] YA_R = 33'sd683160941;
  localparam logic signed [32:0] VB_O = 33'sd188554;
  localparam logic signed [32:0] VB_Y = 33'sd5317;
  localparam logic signed [32:0] VB_R = 33'sd879692;
  localparam logic signed [32:0] VB_V = 33'sd786771;

  // atan(2^-i), Q.30
  localparam logic [31:0] ATAN30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };
  localparam logic [31:0] GAIN30 = 32'd652032874;
  localparam logic [63:0] PI60   = 64'd3622009729038561421;

  localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] a);
    logic signed [31:0] r;
    if (a > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (a < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(a);
    end
    return r;
  endfunction

  // Q.30 to Q.frac, rounded
  function automatic logic [31:0] from30(input logic [31:0] a, input int frac);
    logic [32:0] t;
    if (frac >= 30) begin
      t = 33'(a);
    end else begin
      t = (33'(a) + (33'd1 << (29 - frac))) >> (30 - frac);
    end
    return 32'(t);
  endfunction

  function automatic logic [63:0] pi_q(input int frac);
    return (PI60 + (64'd1 << (59 - frac))) >> (60 - frac);
  endfunction

endpackage

`default_nettype wire

// File: src/syrk_divider.sv
// ----------------------------------------------------------------------------
// syrk_divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module syrk_divider #(
  parameter int W = 36
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int STEPS = W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;

  logic [W:0]   sh1, sh2;
  logic         ge1, ge2;
  logic [W-1:0] r1, r2, q1, q2;

  always_comb begin
    sh1 = {rem, quo[W-1]};
    ge1 = sh1 >= {1'b0, dvs};
    r1  = ge1 ? W'(sh1 - {1'b0, dvs}) : W'(sh1);
    q1  = {quo[W-2:0], ge1};
    sh2 = {r1, q1[W-1]};
    ge2 = sh2 >= {1'b0, dvs};
    r2  = ge2 ? W'(sh2 - {1'b0, dvs}) : W'(sh2);
    q2  = {q1[W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS - 1);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= r2;
      quo <= q2;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// File: src/syrk_cordic.sv
// ----------------------------------------------------------------------------
// syrk_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a heading angle.
// ----------------------------------------------------------------------------
`default_nettype none

module syrk_cordic
  import syrk_pkg::*;
#(
  parameter int FRAC_BITS    = 24,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    busy,
  output logic signed [32:0]      cos_val,
  output logic signed [32:0]      sin_val
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic signed [33:0] PQ      = 34'(pi_q(FRAC_BITS));
  localparam logic signed [33:0] HALF_PQ = PQ >>> 1;
  localparam logic signed [33:0] GAIN    = 34'(from30(GAIN30, FRAC_BITS));

  logic signed [33:0] x, y, z;
  logic               flip;
  logic [CNT_W-1:0]   cnt;

  logic signed [33:0] z0, t, xs, ys;

  always_comb begin
    z0 = 34'(angle);
    t  = 34'(from30(ATAN30[5'(cnt)], FRAC_BITS));
    xs = x >>> cnt;
    ys = y >>> cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      // fold angles beyond +-pi/2 back by pi, flip the result signs later
      if (z0 > HALF_PQ) begin
        z    <= z0 - PQ;
        flip <= 1'b1;
      end else if (z0 < -HALF_PQ) begin
        z    <= z0 + PQ;
        flip <= 1'b1;
      end else begin
        z    <= z0;
        flip <= 1'b0;
      end
      x    <= GAIN;
      y    <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign cos_val = flip ? 33'(-x) : 33'(x);
  assign sin_val = flip ? 33'(-y) : 33'(y);

endmodule

`default_nettype wire

// File: src/ship_yaw_dynamics_rk4_step_top.sv
// ----------------------------------------------------------------------------
// ship_yaw_dynamics_rk4_step_top
// Work per word: 60 products through the shared multiplier, each registered
//   in S_MUL and written back in S_WB, and five divisions through the divider
//   (two quotient bits per cycle); CORDIC runs alongside the RK4.
// Throughput: one word per step; in_ready is high only while idle.
// Reset: synchronous; state returns to surge 1.0, all else 0; registers to
//   their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_yaw_dynamics_rk4_step_top
  import syrk_pkg::*;
#(
  parameter int FRAC_BITS    = 24,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [26:0] rudder_target,
  input  wire logic               restart,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [24:0]             surge_speed,
  output logic signed [31:0]      sway_speed,
  output logic signed [31:0]      yaw_rate,
  output logic signed [31:0]      yaw_accel,
  output logic signed [31:0]      rudder_angle,
  output logic signed [26:0]      target_echo,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [26:0]      heading
);

  localparam int F       = FRAC_BITS;
  localparam int A_W     = 35;        // multiplier port A
  localparam int B_W     = 33;        // multiplier port B
  localparam int P_W     = A_W + B_W; // product
  localparam int R_W     = P_W + 2;   // rounding unit
  localparam int SQ_W    = 2 * F + 2;
  localparam int DIV_RAW = (60 - F > 34) ? 60 - F : 34;
  localparam int DIV_W   = DIV_RAW + (DIV_RAW % 2);

  localparam logic [P_W-1:0]          ONE_P = P_W'(1) << F;
  localparam logic signed [DIV_W:0]   PQ_S  = (DIV_W + 1)'(pi_q(F));
  localparam logic [DIV_W-1:0]        PQ2   = DIV_W'(2 * pi_q(F));
  localparam logic [DIV_W-1:0]        SIX   = DIV_W'(6);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_WB, S_KSUM, S_DIV, S_SQRT, S_CORD, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_OD, OP_YO, OP_YD, OP_YY, OP_YR, OP_VO, OP_VY, OP_VR, OP_VV,
    OP_ST, OP_FIN, OP_VSQ, OP_PX1, OP_PX2, OP_PXH, OP_PY1, OP_PY2, OP_PYH,
    OP_HD
  } op_t;

  // configuration
  logic [24:0] step_size;
  logic [24:0] rudder_rate;

  // sequencer
  state_t     state;
  op_t        op;
  logic [1:0] stg;   // RK4 stage being evaluated
  logic [1:0] ln;    // lane for per-variable passes: sway, yaw rate, yaw accel, rudder

  // state and working registers
  logic signed [26:0]    tgt;
  logic signed [31:0]    st [4];
  logic signed [31:0]    tp [4];
  logic signed [31:0]    kv [4];
  logic signed [A_W-1:0] ksum [4];
  logic signed [31:0]    surge, xs, ys, hd;
  logic signed [31:0]    od, px;
  logic signed [47:0]    acc;
  logic signed [P_W:0]   pacc;
  logic signed [P_W-1:0] prod;
  logic                  fin_neg;
  logic                  hw_neg;
  logic [SQ_W-1:0]       sq_a, sq_r, sq_bit;

  // shared datapath
  logic signed [A_W-1:0] ma;
  logic signed [B_W-1:0] mb;
  logic signed [P_W-1:0] mul_out;
  logic signed [R_W-1:0] rin, rout;
  logic [R_W-1:0]        rmag, rq, rhalf;
  logic [4:0]            rsh;
  logic signed [47:0]    acc_next;
  logic signed [P_W:0]   pacc_next;
  logic signed [24:0]    h_s;

  // CORDIC and divider
  logic                  cord_start, cord_busy;
  logic signed [32:0]    cth, sth;
  logic                  div_start, div_busy;
  logic [DIV_W-1:0]      div_a, div_d, div_q, div_r;

  // misc combinational
  logic                  accept;
  logic                  cfg_wr;
  logic [P_W-1:0]        fin_mag, vv;
  logic signed [DIV_W:0] hw;
  logic [DIV_W-1:0]      hw_mag, hres;
  logic [SQ_W-1:0]       sq_sum, sq_r_next;
  logic                  sq_ge;
  logic                  dbl;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign h_s      = $signed({1'b0, step_size[23:0]}) ;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must land only while idle; the user is bound, the block does not enforce it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= STEP_SIZE_RST;
      rudder_rate <= RUDDER_RATE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STEP_SIZE:   step_size   <= pwdata[24:0];
        REG_RUDDER_RATE: rudder_rate <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STEP_SIZE:   prdata = {7'd0, step_size};
      REG_RUDDER_RATE: prdata = {7'd0, rudder_rate};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand select by micro-op, product registered.
  // The step size is a 25-bit unsigned value, so feed it zero-extended.
  // ---------------------------------------------------------------------------
  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      OP_OD:  begin ma = A_W'(tgt) - A_W'(tp[3]); mb = B_W'(rudder_rate); end
      OP_YO:  begin ma = A_W'(tp[3]); mb = YA_O; end
      OP_YD:  begin ma = A_W'(od);    mb = YA_D; end
      OP_YY:  begin ma = A_W'(tp[2]); mb = YA_Y; end
      OP_YR:  begin ma = A_W'(tp[1]); mb = YA_R; end
      OP_VO:  begin ma = A_W'(tp[3]); mb = VB_O; end
      OP_VY:  begin ma = A_W'(tp[2]); mb = VB_Y; end
      OP_VR:  begin ma = A_W'(tp[1]); mb = VB_R; end
      OP_VV:  begin ma = A_W'(tp[0]); mb = VB_V; end
      OP_ST:  begin ma = A_W'(kv[ln]); mb = B_W'(step_size); end
      OP_FIN: begin ma = ksum[ln];     mb = B_W'(step_size); end
      OP_VSQ: begin ma = A_W'(st[0]);  mb = B_W'(st[0]); end
      OP_PX1: begin ma = A_W'(surge);  mb = cth; end
      OP_PX2: begin ma = A_W'(st[0]);  mb = sth; end
      OP_PXH: begin ma = A_W'(px);     mb = B_W'(step_size); end
      OP_PY1: begin ma = A_W'(surge);  mb = sth; end
      OP_PY2: begin ma = A_W'(st[0]);  mb = cth; end
      OP_PYH: begin ma = A_W'(px);     mb = B_W'(step_size); end
      OP_HD:  begin ma = A_W'(st[1]);  mb = B_W'(step_size); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mul_out = ma * mb;

  // ---------------------------------------------------------------------------
  // Rounding unit: shift right, halves away from zero. Position terms are
  // summed exactly before one rounding, so they feed the running sum here.
  // ---------------------------------------------------------------------------
  always_comb begin
    pacc_next = (op == OP_PX2) ? pacc - (P_W + 1)'(prod) : pacc + (P_W + 1)'(prod);
    if (op == OP_PX2 || op == OP_PY2) begin
      rin = R_W'(pacc_next);
    end else begin
      rin = R_W'(prod);
    end
    case (op)
      OP_YO, OP_YD, OP_YY, OP_YR,
      OP_VO, OP_VY, OP_VR, OP_VV: rsh = 5'(COEF_FRAC);
      OP_ST:                      rsh = (stg == 2'd2) ? 5'(F) : 5'(F + 1);
      default:                    rsh = 5'(F);
    endcase
    rhalf = R_W'(1) << (rsh - 5'd1);
    rmag  = rin[R_W-1] ? R_W'(-rin) : R_W'(rin);
    rq    = (rmag + rhalf) >> rsh;
    rout  = rin[R_W-1] ? -$signed(rq) : $signed(rq);
  end

  // derivative accumulator: each term rounded on its own, then summed
  always_comb begin
    case (op)
      OP_YO, OP_VO: acc_next = 48'(rout);
      OP_YD, OP_VY: acc_next = acc + 48'(rout);
      default:      acc_next = acc - 48'(rout);
    endcase
  end

  // final update: fold the /6 of the weighted sum after dropping the fraction
  always_comb begin
    fin_mag = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
    vv      = (P_W'(prod) + (P_W'(1) << (F - 1))) >> F;
    hw      = (DIV_W + 1)'(hd) + (DIV_W + 1)'(rout) + PQ_S;
    hw_mag  = hw[DIV_W] ? DIV_W'(-hw) : DIV_W'(hw);
    hres    = (hw_neg && div_r != '0) ? PQ2 - div_r : div_r;
    div_start = (state == S_WB) && (op == OP_FIN || op == OP_HD);
    if (op == OP_HD) begin
      div_a = hw_mag;
      div_d = PQ2;
    end else begin
      div_a = DIV_W'((fin_mag + (P_W'(3) << F)) >> F);
      div_d = SIX;
    end
  end

  // square root, one result bit per cycle
  always_comb begin
    sq_sum    = sq_r + sq_bit;
    sq_ge     = sq_a >= sq_sum;
    sq_r_next = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;
  end

  assign dbl        = (stg == 2'd1) || (stg == 2'd2);
  assign cord_start = accept;

  // ---------------------------------------------------------------------------
  // Sequencer. For each product S_MUL registers it, then S_WB
  // rounds and writes it back. Order per step: four derivative passes
  // (nine products each) with stage points between them, the final update
  // through the divider, surge by square root, position, then heading wrap.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_OD;
      stg       <= '0;
      ln        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        st[i] <= '0;
      end
      surge <= 32'(ONE_P);
      xs    <= '0;
      ys    <= '0;
      hd    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            tgt <= rudder_target;
            if (restart) begin
              for (int i = 0; i < 4; i++) begin
                st[i] <= '0;
                tp[i] <= '0;
              end
              surge <= 32'(ONE_P);
              xs    <= '0;
              ys    <= '0;
              hd    <= '0;
            end else begin
              for (int i = 0; i < 4; i++) begin
                tp[i] <= st[i];
              end
            end
            stg   <= '0;
            op    <= OP_OD;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod  <= mul_out;
          state <= S_WB;
        end

        S_WB: begin
          state <= S_MUL;
          case (op)
            OP_OD: begin od <= sat32(72'(rout)); op <= OP_YO; end
            OP_YO: begin acc <= acc_next; op <= OP_YD; end
            OP_YD: begin acc <= acc_next; op <= OP_YY; end
            OP_YY: begin acc <= acc_next; op <= OP_YR; end
            OP_YR: begin
              kv[2] <= sat32(72'(acc_next));
              op    <= OP_VO;
            end
            OP_VO: begin acc <= acc_next; op <= OP_VY; end
            OP_VY: begin acc <= acc_next; op <= OP_VR; end
            OP_VR: begin acc <= acc_next; op <= OP_VV; end
            OP_VV: begin
              kv[0] <= sat32(72'(acc_next));
              kv[1] <= tp[2];
              kv[3] <= od;
              state <= S_KSUM;
            end
            OP_ST: begin
              // next stage point: half step for stages two and three, full for four
              tp[ln] <= sat32(72'(st[ln]) + 72'(rout));
              ln     <= ln + 1'b1;
              if (ln == 2'd3) begin
                stg <= stg + 1'b1;
                op  <= OP_OD;
              end
            end
            OP_FIN: begin
              fin_neg <= prod[P_W-1];
              state   <= S_DIV;
            end
            OP_VSQ: begin
              if (vv >= ONE_P) begin
                surge <= '0;
                state <= S_CORD;
              end else begin
                sq_a   <= SQ_W'((ONE_P - vv) << F);
                sq_r   <= '0;
                sq_bit <= SQ_W'(1) << (2 * F);
                state  <= S_SQRT;
              end
            end
            OP_PX1: begin pacc <= (P_W + 1)'(prod); op <= OP_PX2; end
            OP_PX2: begin px <= sat32(72'(rout)); op <= OP_PXH; end
            OP_PXH: begin xs <= sat32(72'(xs) + 72'(rout)); op <= OP_PY1; end
            OP_PY1: begin pacc <= (P_W + 1)'(prod); op <= OP_PY2; end
            OP_PY2: begin px <= sat32(72'(rout)); op <= OP_PYH; end
            OP_PYH: begin ys <= sat32(72'(ys) + 72'(rout)); op <= OP_HD; end
            OP_HD: begin
              hw_neg <= hw[DIV_W];
              state  <= S_DIV;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_KSUM: begin
          // weighted sum k1 + 2k2 + 2k3 + k4
          for (int i = 0; i < 4; i++) begin
            ksum[i] <= ((stg == 2'd0) ? '0 : ksum[i])
                     + (dbl ? A_W'(kv[i]) <<< 1 : A_W'(kv[i]));
          end
          ln    <= '0;
          op    <= (stg == 2'd3) ? OP_FIN : OP_ST;
          state <= S_MUL;
        end

        S_DIV: begin
          if (!div_busy) begin
            if (op == OP_HD) begin
              // floor modulo 2pi, then shift back to [-pi, pi)
              hd    <= sat32($signed(72'(hres)) - 72'(PQ_S));
              state <= S_DONE;
            end else begin
              st[ln] <= sat32(72'(st[ln])
                        + (fin_neg ? -$signed(72'(div_q)) : $signed(72'(div_q))));
              ln     <= ln + 1'b1;
              op     <= (ln == 2'd3) ? OP_VSQ : OP_FIN;
              state  <= S_MUL;
            end
          end
        end

        S_SQRT: begin
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          if (sq_ge) begin
            sq_a <= sq_a - sq_sum;
          end
          if (sq_bit[0]) begin
            surge <= 32'(sq_r_next);
            state <= S_CORD;
          end
        end

        S_CORD: begin
          // heading trig was started at accept; it is long done by now
          if (!cord_busy) begin
            op    <= OP_PX1;
            state <= S_MUL;
          end
        end

        S_DONE: begin
          // hold the finished word until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            surge_speed  <= surge[24:0];
            sway_speed   <= st[0];
            yaw_rate     <= st[1];
            yaw_accel    <= st[2];
            rudder_angle <= st[3];
            target_echo  <= tgt;
            pos_x        <= xs;
            pos_y        <= ys;
            heading      <= hd[26:0];
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  syrk_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .angle   (restart ? 32'sd0 : hd),
    .busy    (cord_busy),
    .cos_val (cth),
    .sin_val (sth)
  );

  syrk_divider #(
    .W (DIV_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_d),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

endmodule

`default_nettype wire

// File: tb/ship_yaw_dynamics_rk4_step_checker.sv
// ----------------------------------------------------------------------------
// ship_yaw_dynamics_rk4_step_checker
// Watches the configuration port and both word channels of the ship yaw RK4
// step block, predicts every result word from its own copy of the state and
// compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_yaw_dynamics_rk4_step_checker
  import syrk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [26:0] rudder_target,
  input  wire logic               restart,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [24:0]        surge_speed,
  input  wire logic signed [31:0] sway_speed,
  input  wire logic signed [31:0] yaw_rate,
  input  wire logic signed [31:0] yaw_accel,
  input  wire logic signed [31:0] rudder_angle,
  input  wire logic signed [26:0] target_echo,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [26:0] heading,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam int ROT_STEPS = 24;
  localparam longint ONE = longint'(1) << FRAC;

  typedef struct {
    logic [24:0] surge;
    logic [31:0] sway;
    logic [31:0] yaw;
    logic [31:0] accel;
    logic [31:0] rudder;
    logic [26:0] target;
    logic [31:0] px;
    logic [31:0] py;
    logic [26:0] head;
  } ship_word_t;

  typedef longint vec4_t [4];

  ship_word_t ship_expected_q [$];

  longint h_step, lag_rate;
  longint st_surge, st_v, st_r, st_y, st_o, st_x, st_py, st_head;

  function automatic longint clamp_word(input longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // halves go away from zero
  function automatic longint div_round(input longint x, input longint d);
    longint m, q;
    m = (x < 0) ? -x : x;
    q = (m + d / 2) / d;
    return (x < 0) ? -q : q;
  endfunction

  function automatic longint coef_mul(input longint s, input longint c);
    return div_round(s * c, longint'(1) << COEF_FRAC);
  endfunction

  function automatic longint q30_to_frac(input longint a);
    return (a + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint pi_frac();
    return (longint'(PI60) + (longint'(1) << (59 - FRAC))) >>> (60 - FRAC);
  endfunction

  function automatic void rates_of(input vec4_t s, input longint tgt, output vec4_t d);
    longint od;
    od = clamp_word(div_round(lag_rate * (tgt - s[3]), ONE));
    d[3] = od;
    d[1] = s[2];
    d[2] = clamp_word(coef_mul(s[3], longint'(YA_O)) + coef_mul(od, longint'(YA_D))
                      - coef_mul(s[2], longint'(YA_Y)) - coef_mul(s[1], longint'(YA_R)));
    d[0] = clamp_word(coef_mul(s[3], longint'(VB_O)) + coef_mul(s[2], longint'(VB_Y))
                      - coef_mul(s[1], longint'(VB_R)) - coef_mul(s[0], longint'(VB_V)));
  endfunction

  function automatic void stage_point(input vec4_t s, input vec4_t k, input longint dv,
                                      output vec4_t t);
    for (int i = 0; i < 4; i++) t[i] = clamp_word(s[i] + div_round(h_step * k[i], dv));
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint pq, x, y, z, nx, t;
    bit flip;
    pq = pi_frac();
    z = ang;
    flip = 0;
    if (z > pq / 2) begin
      z -= pq;
      flip = 1;
    end else if (z < -(pq / 2)) begin
      z += pq;
      flip = 1;
    end
    x = q30_to_frac(longint'(GAIN30));
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      t = q30_to_frac(longint'(ATAN30[i & 31]));
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= t;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += t;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void load_start_state();
    st_surge = ONE;
    st_v = 0; st_r = 0; st_y = 0; st_o = 0;
    st_x = 0; st_py = 0; st_head = 0;
  endfunction

  // advance the ship by one tick and return the word it should report
  function automatic ship_word_t advance_ship(input logic signed [26:0] tgt_in, input logic rs);
    ship_word_t w;
    vec4_t s, k1, k2, k3, k4, t;
    longint tgt, pq, cth, sth, a, wr, vv;
    tgt = longint'(tgt_in);
    pq = pi_frac();
    if (rs) load_start_state();
    s[0] = st_v; s[1] = st_r; s[2] = st_y; s[3] = st_o;
    rates_of(s, tgt, k1);
    stage_point(s, k1, 2 * ONE, t); rates_of(t, tgt, k2);
    stage_point(s, k2, 2 * ONE, t); rates_of(t, tgt, k3);
    stage_point(s, k3, ONE, t);     rates_of(t, tgt, k4);
    for (int i = 0; i < 4; i++)
      s[i] = clamp_word(s[i] + div_round(h_step * (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]),
                                         6 * ONE));
    st_v = s[0]; st_r = s[1]; st_y = s[2]; st_o = s[3];

    vv = div_round(st_v * st_v, ONE);
    if (vv >= ONE) st_surge = 0;
    else st_surge = longint'(int_sqrt(longint'(unsigned'(ONE - vv)) << FRAC));

    sin_cos(st_head, cth, sth);
    a = st_surge * cth - st_v * sth;
    st_x = clamp_word(st_x + div_round(h_step * clamp_word(div_round(a, ONE)), ONE));
    a = st_surge * sth + st_v * cth;
    st_py = clamp_word(st_py + div_round(h_step * clamp_word(div_round(a, ONE)), ONE));

    wr = st_head + div_round(h_step * st_r, ONE) + pq;
    wr = wr % (2 * pq);
    if (wr < 0) wr += 2 * pq;
    st_head = clamp_word(wr - pq);

    w.surge = st_surge[24:0];
    w.sway = st_v[31:0];
    w.yaw = st_r[31:0];
    w.accel = st_y[31:0];
    w.rudder = st_o[31:0];
    w.target = tgt_in;
    w.px = st_x[31:0];
    w.py = st_py[31:0];
    w.head = st_head[26:0];
    return w;
  endfunction

  function automatic void check_field(input string nm, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", nm, exp_v, act_v);
    end
  endfunction

  assign pending_count = ship_expected_q.size();

  always @(posedge clk) begin
    ship_word_t e;
    if (rst) begin
      h_step <= longint'(STEP_SIZE_RST);
      lag_rate <= longint'(RUDDER_RATE_RST);
      load_start_state();
      ship_expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_STEP_SIZE) h_step <= longint'(pwdata[24:0]);
        else lag_rate <= longint'(pwdata[24:0]);
      end
      if (in_valid && in_ready) ship_expected_q.push_back(advance_ship(rudder_target, restart));
      if (out_valid && out_ready) begin
        if (ship_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word");
        end else begin
          e = ship_expected_q.pop_front();
          check_field("surge_speed", 32'(e.surge), 32'(surge_speed));
          check_field("sway_speed", e.sway, sway_speed);
          check_field("yaw_rate", e.yaw, yaw_rate);
          check_field("yaw_accel", e.accel, yaw_accel);
          check_field("rudder_angle", e.rudder, rudder_angle);
          check_field("target_echo", 32'(e.target), 32'(unsigned'(target_echo)));
          check_field("pos_x", e.px, pos_x);
          check_field("pos_y", e.py, pos_y);
          check_field("heading", 32'(e.head), 32'(unsigned'(heading)));
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

`default_nettype wire

// File: tb/ship_yaw_dynamics_rk4_step_top_tb.sv
// ----------------------------------------------------------------------------
// ship_yaw_dynamics_rk4_step_top_tb
// Drives rudder command words through several step size and rudder lag
// settings, with random idling on both channels; a checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_yaw_dynamics_rk4_step_top_tb
  import syrk_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [26:0] PI_POS = 27'sd52707179;
  localparam logic signed [26:0] PI_NEG = -27'sd52707179;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [26:0] rudder_target = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [24:0] surge_speed;
  logic signed [31:0] sway_speed, yaw_rate, yaw_accel, rudder_angle, pos_x, pos_y;
  logic signed [26:0] target_echo, heading;
  int fail_count, pending_count;
  bit steady;        // no idling on either side while set
  int ticks_sent;
  int settings_run;

  always #10 clk = ~clk;

  ship_yaw_dynamics_rk4_step_top u_top (.*);

  ship_yaw_dynamics_rk4_step_checker u_chk (.*);

  // the receiver stalls about 37 percent of the time outside steady stretches
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 37);
  end

  // one register write: setup cycle, then access cycle
  task automatic reg_write(input logic idx, input logic [24:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drop valid and hold until every expected word has come back
  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  // set both registers between phases, with the block idle
  task automatic apply_rates(input logic [24:0] h, input logic [24:0] rate);
    drain();
    reg_write(REG_STEP_SIZE, h);
    reg_write(REG_RUDDER_RATE, rate);
    settings_run++;
  endtask

  // present one tick word and hold it until accepted
  task automatic send_tick(input logic signed [26:0] tgt, input logic rs);
    if (!steady && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rudder_target <= tgt;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // mostly commands inside +-pi, some full-width words, rare restarts
  task automatic send_random(input int n);
    logic signed [26:0] tgt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) tgt = 27'($urandom_range(0, 105414358)) - PI_POS;
      else tgt = 27'($urandom);
      send_tick(tgt, $urandom_range(0, 99) < 5);
    end
  endtask

  initial begin
    #50ms;
    $display("FAIL ship_yaw_dynamics_rk4_step_top");
    $finish;
  end

  initial begin
    steady = 0;
    ticks_sent = 0;
    settings_run = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of the command, restart, full-width words
    send_tick(27'sd0, 1'b1);
    send_tick(PI_POS, 1'b0);
    send_tick(PI_POS, 1'b0);
    send_tick(PI_NEG, 1'b0);
    send_tick(27'sh3FFFFFF, 1'b0);
    send_tick(27'sh4000000, 1'b0);
    send_tick(-27'sd1, 1'b1);
    send_tick(27'sd1, 1'b0);
    send_tick(27'sh2AAAAAA, 1'b0);
    send_tick(27'sh5555555, 1'b1);

    // largest step and rate: drive the state into saturation and wrap
    apply_rates(25'd16777216, 25'd16777216);
    for (int i = 0; i < 4; i++) send_tick(PI_POS, 1'b0);
    send_tick(27'sh3FFFFFF, 1'b0);
    send_tick(27'sh4000000, 1'b0);

    // zero step and zero rate freeze the state
    apply_rates(25'd0, 25'd0);
    send_tick(PI_POS, 1'b0);
    send_tick(PI_NEG, 1'b1);
    apply_rates(25'd167772, 25'd0);
    send_tick(PI_POS, 1'b0);
    send_tick(PI_POS, 1'b0);

    // smallest nonzero settings
    apply_rates(25'd1, 25'd1);
    send_tick(PI_NEG, 1'b0);
    send_tick(27'sh4000000, 1'b0);

    // defaults, long random run with a stretch where nobody idles
    apply_rates(STEP_SIZE_RST, RUDDER_RATE_RST);
    send_tick(27'sd0, 1'b1);
    send_random(60);
    steady = 1;
    send_random(60);
    steady = 0;
    send_random(40);

    // extremes and random settings between drained phases
    apply_rates(25'd1, 25'd1);
    send_random(40);
    apply_rates(25'd16777216, 25'd16777216);
    send_random(30);
    apply_rates(25'd0, 25'd0);
    send_random(20);
    for (int p = 0; p < 3; p++) begin
      apply_rates(25'($urandom_range(1, 16777216)), 25'($urandom_range(1, 16777216)));
      send_tick(27'sd0, 1'b1);
      send_random(45);
    end
    apply_rates(STEP_SIZE_RST, RUDDER_RATE_RST);
    send_tick(27'sd0, 1'b1);
    send_random(50);

    // hold until everything is back, then let the block settle
    drain();
    repeat (300) @(posedge clk);

    $display("covered %0d tick words over %0d register settings", ticks_sent, settings_run);
    $display("with random idling on both channels and %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("PASS ship_yaw_dynamics_rk4_step_top");
    end else begin
      $display("FAIL ship_yaw_dynamics_rk4_step_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/syrk_pkg.sv
src/syrk_divider.sv
src/syrk_cordic.sv
src/ship_yaw_dynamics_rk4_step_top.sv
tb/ship_yaw_dynamics_rk4_step_checker.sv
tb/ship_yaw_dynamics_rk4_step_top_tb.sv
